[sv/wafb_pkg.sv]
// Shared types, constants and constant-divide helpers for the wheel axes force feedback core.
package wafb_pkg;

  localparam int POSITION_BITS = 32;
  localparam int W9_BITS       = POSITION_BITS + 4;

  typedef enum logic [1:0] {
    CMD_ENCODER = 2'd0,
    CMD_HOST    = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MOTOR_OFF = 2'd0,
    MOTOR_FWD = 2'd1,
    MOTOR_REV = 2'd2
  } motor_dir_t;

  localparam logic [7:0] REPORT_SET_FORCE = 8'h11;
  localparam logic [7:0] REPORT_STOP      = 8'h13;
  localparam logic [7:0] FORCE_CENTRE     = 8'd128;
  localparam logic [7:0] FORCE_CENTRE_LO  = 8'd127;

  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_UP_LEFT    = 4'd7;
  localparam logic [3:0] HAT_CENTRED    = 4'd8;

  // Thresholds on nine times the wheel position.
  localparam logic signed [W9_BITS-1:0] W9_LOW_STOP  = W9_BITS'(1270);
  localparam logic signed [W9_BITS-1:0] W9_HIGH_STOP = W9_BITS'(39680);
  localparam logic signed [W9_BITS-1:0] W9_LOW_NUM   = W9_BITS'(2550);
  localparam logic signed [W9_BITS-1:0] W9_HIGH_NUM  = W9_BITS'(40950);
  localparam logic signed [W9_BITS-1:0] W9_LOW_SAT   = -W9_BITS'(10);
  localparam logic signed [W9_BITS-1:0] W9_ZERO      = '0;

  typedef struct packed {
    logic [15:0] key_matrix;
    logic [9:0]  shifter_y;
    logic [9:0]  shifter_x;
    logic [9:0]  pedal_c;
    logic [9:0]  pedal_b;
    logic [9:0]  pedal_a;
    logic [7:0]  force_byte;
    logic [7:0]  report_kind;
    logic        phase_b;
    logic        phase_a;
    logic [1:0]  cmd;
  } in_item_t;

  typedef struct packed {
    logic [11:0] wheel_axis;
    logic [1:0]  motor_direction;
    logic [7:0]  motor_duty;
  } wheel_res_t;

  typedef struct packed {
    logic [11:0] combined_axis;
    logic [11:0] pedal_a_axis;
    logic [11:0] pedal_b_axis;
    logic [11:0] pedal_c_axis;
    logic [18:0] button_bits;
    logic [3:0]  hat_direction;
  } panel_res_t;

  // Exact x/10 for any 16-bit x, by reciprocal multiplication.
  function automatic logic [12:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd52429;
    return p[31:19];
  endfunction

  // Exact x/100 for any 19-bit x, by reciprocal multiplication.
  function automatic logic [12:0] div100(input logic [18:0] x);
    logic [38:0] p;
    p = 39'(x) * 39'd671089;
    return p[38:26];
  endfunction

endpackage

[sv/wheel_axes_force_feedback_core.sv]
// Top level of the wheel axes force feedback core: input register, compute and result register.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | slave     | in_tvalid/tready   | in_tdata: command and sample fields
//  out_    | master    | out_tvalid/tready  | out_tdata: axes, buttons, hat and motor
//
// An item is registered on acceptance and processed from the input register; a report tick
// item gives its result in the output register. One item can be accepted in every cycle
// unless a held tick waits on out_tready. Encoder and host items give no result.
// Reset (rst_n low at a clock edge) empties both registers and restores the pending count
// to zero, the wheel position to 2275 and the force level to 128.
// While a result waits on out_tready, encoder and host items still pass; a further tick
// holds in the input register, and in_tready falls only once that register is occupied.
module wheel_axes_force_feedback_core
  import wafb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: cmd[1:0], phase_a[2], phase_b[3], report_kind[11:4],
  // force_byte[19:12], pedal_a[29:20], pedal_b[39:30], pedal_c[49:40],
  // shifter_x[59:50], shifter_y[69:60], key_matrix[85:70], zero pad[87:86].
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: wheel_axis[11:0], combined_axis[23:12], pedal_a_axis[35:24],
  // pedal_b_axis[47:36], pedal_c_axis[59:48], button_bits[78:60], hat_direction[82:79],
  // motor_direction[84:83], motor_duty[92:85], zero pad[95:93].
  output logic [95:0] out_tdata
);

  // Input register stage.
  in_item_t   hold_r;
  logic       hold_valid_r, hold_valid_nxt;

  // Result register stage.
  logic       res_valid_r, res_valid_nxt;
  wheel_res_t wheel_res_r;
  panel_res_t panel_res_r;

  wheel_res_t wheel_res;
  panel_res_t panel_res;

  logic is_tick;
  logic advance;
  logic in_take;

  // The held item moves on when it produces nothing, or when the result register is free
  // or being emptied in this cycle. State in the force unit updates on that same edge.
  assign is_tick   = (hold_r.cmd == CMD_TICK);
  assign advance   = hold_valid_r && (!is_tick || !res_valid_r || out_tready);
  assign in_tready = !hold_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end

    res_valid_nxt = res_valid_r;
    if (advance && is_tick) begin
      res_valid_nxt = 1'b1;
    end else if (out_tready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_item_t'(in_tdata[85:0]);
    end
    if (advance && is_tick) begin
      wheel_res_r <= wheel_res;
      panel_res_r <= panel_res;
    end
  end

  wafb_force u_force (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (hold_r),
    .result (wheel_res)
  );

  wafb_panel u_panel (
    .item   (hold_r),
    .result (panel_res)
  );

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {3'b000,
                       wheel_res_r.motor_duty,
                       wheel_res_r.motor_direction,
                       panel_res_r.hat_direction,
                       panel_res_r.button_bits,
                       panel_res_r.pedal_c_axis,
                       panel_res_r.pedal_b_axis,
                       panel_res_r.pedal_a_axis,
                       panel_res_r.combined_axis,
                       wheel_res_r.wheel_axis};

endmodule

[sv/wafb_force.sv]
// Encoder count, wheel position and force level state with the wheel axis and motor drive.
module wafb_force
  import wafb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_item_t   item,
  output wheel_res_t result
);

  logic [7:0]                      pending_r, pending_nxt;
  logic signed [POSITION_BITS-1:0] position_r, position_nxt;
  logic [7:0]                      level_r, level_nxt;

  logic signed [POSITION_BITS-1:0] w_new;
  logic signed [W9_BITS-1:0]       w_ext, w9;
  logic [7:0]                      force_val;
  logic [12:0]                     q_low, q_high, q_axis;

  // Fold the signed pending count into the position and form nine times the result.
  always_comb begin
    w_new = position_r + {{(POSITION_BITS-8){pending_r[7]}}, pending_r};
    w_ext = {{4{w_new[POSITION_BITS-1]}}, w_new};
    w9    = (w_ext <<< 3) + w_ext;
  end

  always_comb begin
    q_low  = div10(16'(W9_LOW_NUM - w9));
    q_high = div10(16'(W9_HIGH_NUM - w9));
    q_axis = div10(16'(w9));
  end

  always_comb begin
    if ((level_r == FORCE_CENTRE_LO) || (level_r == FORCE_CENTRE)) begin
      force_val = FORCE_CENTRE;
    end else begin
      force_val = level_r;
    end
    if (w9 < W9_LOW_STOP) begin
      force_val = (w9 <= W9_LOW_SAT) ? 8'd255 : q_low[7:0];
    end
    if (w9 > W9_HIGH_STOP) begin
      force_val = (w9 >= W9_HIGH_NUM) ? 8'd0 : q_high[7:0];
    end

    if (force_val > FORCE_CENTRE) begin
      result.motor_direction = MOTOR_FWD;
      result.motor_duty      = 8'(force_val << 1);
    end else if (force_val == FORCE_CENTRE) begin
      result.motor_direction = MOTOR_OFF;
      result.motor_duty      = 8'd1;
    end else begin
      result.motor_direction = MOTOR_REV;
      result.motor_duty      = 8'(8'd254 - 8'(force_val << 1));
    end

    if (w9 < W9_ZERO) begin
      result.wheel_axis = 12'd0;
    end else if (w9 >= W9_HIGH_NUM) begin
      result.wheel_axis = 12'd4095;
    end else begin
      result.wheel_axis = q_axis[11:0];
    end
  end

  always_comb begin
    pending_nxt  = pending_r;
    position_nxt = position_r;
    level_nxt    = level_r;
    if (step) begin
      case (item.cmd)
        CMD_ENCODER: begin
          pending_nxt = (item.phase_a == item.phase_b) ? pending_r + 8'd1 : pending_r - 8'd1;
        end
        CMD_HOST: begin
          if (item.report_kind == REPORT_SET_FORCE) begin
            level_nxt = item.force_byte;
          end else if (item.report_kind == REPORT_STOP) begin
            level_nxt = FORCE_CENTRE;
          end
        end
        CMD_TICK: begin
          position_nxt = w_new;
          pending_nxt  = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 8'd0;
      position_r <= POSITION_BITS'(2275);
      level_r    <= FORCE_CENTRE;
    end else begin
      pending_r  <= pending_nxt;
      position_r <= position_nxt;
      level_r    <= level_nxt;
    end
  end

endmodule

[sv/wafb_panel.sv]
// Pedal scaling, gear shifter zones and key matrix decoding for one report.
module wafb_panel
  import wafb_pkg::*;
(
  input  in_item_t   item,
  output panel_res_t result
);

  logic [9:0]  za_win, zr_win, sl_base;
  logic [12:0] za_q, zr_q;
  logic [18:0] zr_num;
  logic [11:0] za, zr;
  logic [15:0] m;
  logic [9:0]  gx, gy;
  logic        left, up, right, down;
  logic        y_high, y_low, x_z1, x_z2, x_z3, x_z4;

  always_comb begin
    if (item.pedal_a > 10'd250) begin
      za_win = (item.pedal_a < 10'd900) ? item.pedal_a - 10'd250 : 10'd650;
    end else begin
      za_win = 10'd0;
    end
    za_q = div10(16'(za_win) * 16'd63);
    za   = za_q[11:0];

    if (item.pedal_b > 10'd200) begin
      zr_win = (item.pedal_b < 10'd900) ? item.pedal_b - 10'd200 : 10'd700;
    end else begin
      zr_win = 10'd0;
    end
    zr_num = 19'd409500 - 19'(19'(zr_win) * 19'd585);
    zr_q   = div100(zr_num);
    zr     = zr_q[11:0];

    sl_base = (item.pedal_c > 10'd204) ? item.pedal_c - 10'd204 : 10'd0;

    result.pedal_a_axis  = za;
    result.pedal_b_axis  = zr;
    result.pedal_c_axis  = 12'(12'(sl_base) * 12'd5);
    result.combined_axis = 12'd2048 + (za >> 1) - (zr >> 1);

    m     = item.key_matrix;
    gx    = item.shifter_x;
    gy    = item.shifter_y;
    left  = m[10];
    up    = m[12];
    right = m[13];
    down  = m[14];

    y_high = gy > 10'd690;
    y_low  = gy < 10'd615;
    x_z1   = gx > 10'd585;
    x_z2   = (gx < 10'd585) && (gx > 10'd530);
    x_z3   = (gx < 10'd530) && (gx > 10'd480);
    x_z4   = gx < 10'd480;

    result.button_bits = {m[9], m[8], m[6], m[5],
                          y_low & x_z4, y_low & x_z3, y_high & x_z3,
                          y_low & x_z2, y_high & x_z2, y_low & x_z1, y_high & x_z1,
                          m[15], m[11], m[7], m[3], m[4], m[2], m[1], m[0]};

    if (up) begin
      result.hat_direction = left ? HAT_UP_LEFT : (right ? HAT_UP_RIGHT : HAT_UP);
    end else if (down) begin
      result.hat_direction = left ? HAT_DOWN_LEFT : (right ? HAT_DOWN_RIGHT : HAT_DOWN);
    end else if (left) begin
      result.hat_direction = HAT_LEFT;
    end else if (right) begin
      result.hat_direction = HAT_RIGHT;
    end else begin
      result.hat_direction = HAT_CENTRED;
    end
  end

endmodule
